>>> sv/rnsd_pkg.sv
// ----------------------------------------------------------------------------
// rnsd_pkg
// Types, codes and helpers shared by the sprite body decoder and its channels.
// ----------------------------------------------------------------------------
package rnsd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    typedef logic [7:0]  byte_t;
    typedef logic [14:0] width_t;
    typedef logic [15:0] column_t;
    typedef logic [8:0]  visible_t;

    // register indexes on the configuration channel
    localparam cfg_index_t REG_IMAGE_WIDTH      = 3'd0;
    localparam cfg_index_t REG_IMAGE_HEIGHT     = 3'd1;
    localparam cfg_index_t REG_PALETTE_BASE     = 3'd2;
    localparam cfg_index_t REG_COMPRESSED_MODE  = 3'd3;
    localparam cfg_index_t REG_TRANSPARENT_MODE = 3'd4;

    // decoder phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_REPEAT  = 3'd1;
    localparam logic [2:0] PH_LITERAL = 3'd2;
    localparam logic [2:0] PH_PAD     = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    localparam logic [1:0] PAD_BYTES = 2'd2;

    function automatic byte_t map_nibble(input logic [3:0] nib, input byte_t base,
                                         input logic transparent);
        byte_t idx;
        idx = base + {4'd0, nib};
        if (transparent && (nib == 4'd0))
        begin
            idx = 8'd0;
        end
        return idx;
    endfunction

endpackage

>>> sv/rnsd_if.sv
// ----------------------------------------------------------------------------
// rnsd_if
// Valid/ready channels of the sprite body decoder: body bytes, decoded runs
// and configuration writes.
// ----------------------------------------------------------------------------
interface rnsd_byte_if;
    logic             valid;
    logic             ready;
    rnsd_pkg::byte_t  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rnsd_run_if;
    logic                valid;
    logic                ready;
    rnsd_pkg::byte_t     pixel_even;
    rnsd_pkg::byte_t     pixel_odd;
    rnsd_pkg::byte_t     pair_repeat;
    rnsd_pkg::column_t   start_column;
    rnsd_pkg::byte_t     line_number;
    rnsd_pkg::visible_t  visible_pixels;
    logic                line_done;
    logic                image_done;

    modport source (output valid, output pixel_even, output pixel_odd,
                    output pair_repeat, output start_column, output line_number,
                    output visible_pixels, output line_done, output image_done,
                    input ready);
    modport sink   (input valid, input pixel_even, input pixel_odd,
                    input pair_repeat, input start_column, input line_number,
                    input visible_pixels, input line_done, input image_done,
                    output ready);
endinterface

interface rnsd_cfg_if;
    logic                  valid;
    logic                  ready;
    rnsd_pkg::cfg_index_t  index;
    rnsd_pkg::cfg_data_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/rle_nibble_sprite_decoder.sv
// ----------------------------------------------------------------------------
// rle_nibble_sprite_decoder
// Run-length 4bpp sprite body decoder: body bytes in, runs of pixel pairs out.
// ----------------------------------------------------------------------------
// One body byte is taken per clock. Each byte is decoded in a single pass:
// the phase, run counter, column and row are updated in the cycle the byte
// is accepted and any run it produces lands in the result register in that
// same cycle. The only thing that holds the input back is the result
// register: a new byte is taken whenever that register is empty or is being
// read in the same cycle. Count and padding bytes give no run. After the
// sprite ends all further bytes are taken and dropped until reset.
// Configuration writes are always accepted and are meant for idle periods.
module rle_nibble_sprite_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    rnsd_cfg_if.sink   cfg,
    rnsd_byte_if.sink  body,
    rnsd_run_if.source run
);
    import rnsd_pkg::*;

    // configuration
    width_t     width_reg;
    byte_t      height_reg;
    byte_t      base_reg;
    logic       compressed_reg;
    logic       transparent_reg;

    // decoder state
    logic [2:0] phase_reg, phase_next;
    byte_t      left_reg, left_next;
    column_t    col_reg, col_next;
    byte_t      row_reg, row_next;
    logic       parity_reg, parity_next;
    logic [1:0] pad_reg, pad_next;

    // result register
    logic       out_valid_reg;
    byte_t      even_reg, odd_reg, rep_reg, line_no_reg;
    column_t    start_reg;
    visible_t   vis_reg;
    logic       line_done_reg, image_done_reg;

    logic       take;
    logic       emit;
    logic       check;
    byte_t      rep;
    logic [8:0] span;
    column_t    col_sum;
    column_t    room;
    visible_t   vis;
    logic       line_end;
    logic       img_end;
    byte_t      row_inc;

    assign cfg.ready  = 1'b1;
    assign body.ready = !out_valid_reg || run.ready;
    assign take       = body.valid && body.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= 15'd1;
            height_reg      <= 8'd1;
            base_reg        <= 8'd0;
            compressed_reg  <= 1'b1;
            transparent_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:      width_reg       <= cfg.data[14:0];
                REG_IMAGE_HEIGHT:     height_reg      <= cfg.data[7:0];
                REG_PALETTE_BASE:     base_reg        <= cfg.data[7:0];
                REG_COMPRESSED_MODE:  compressed_reg  <= cfg.data[0];
                REG_TRANSPARENT_MODE: transparent_reg <= cfg.data[0];
                default:              ;
            endcase
        end
    end

    // phase decode: what this byte is and which run it forms
    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        parity_next = parity_reg;
        pad_next    = pad_reg;
        emit        = 1'b0;
        check       = 1'b0;
        rep         = 8'd1;
        case (phase_reg)
            PH_IDLE:
            begin
                if (parity_reg)
                begin
                    parity_next = 1'b0;
                    emit        = 1'b1;
                    check       = 1'b1;
                end
                else if (!compressed_reg)
                begin
                    parity_next = 1'b1;
                    emit        = 1'b1;
                end
                else if (body.data_byte[7])
                begin
                    // 1 - signed count, 2..129
                    left_next  = ~body.data_byte + 8'd2;
                    phase_next = PH_REPEAT;
                end
                else
                begin
                    left_next  = {1'b0, body.data_byte[6:0]} + 8'd1;
                    phase_next = PH_LITERAL;
                end
            end
            PH_REPEAT:
            begin
                rep        = left_reg;
                left_next  = 8'd0;
                phase_next = PH_IDLE;
                emit       = 1'b1;
                check      = 1'b1;
            end
            PH_LITERAL:
            begin
                left_next = left_reg - 8'd1;
                emit      = 1'b1;
                if (left_reg == 8'd1)
                begin
                    phase_next = PH_IDLE;
                    check      = 1'b1;
                end
            end
            PH_PAD:
            begin
                pad_next = pad_reg - 2'd1;
                if (pad_reg == 2'd1)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default: ;
        endcase

        // run geometry and the line / sprite end checks
        span    = {rep, 1'b0};
        col_sum = col_reg + {7'd0, span};
        room    = {1'b0, width_reg} - col_reg;
        vis     = 9'd0;
        if (col_reg < {1'b0, width_reg})
        begin
            vis = (room > {7'd0, span}) ? span : room[8:0];
        end
        line_end = check && (col_sum >= {1'b0, width_reg});
        row_inc  = line_end ? row_reg + 8'd1 : row_reg;
        img_end  = check && (row_inc >= height_reg);

        col_next = emit ? (line_end ? 16'd0 : col_sum) : col_reg;
        row_next = row_inc;
        if (line_end && (col_sum[1:0] == 2'd2) && (phase_next == PH_IDLE))
        begin
            phase_next = PH_PAD;
            pad_next   = PAD_BYTES;
        end
        if (img_end)
        begin
            phase_next = PH_DONE;
            pad_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            left_reg   <= 8'd0;
            col_reg    <= 16'd0;
            row_reg    <= 8'd0;
            parity_reg <= 1'b0;
            pad_reg    <= 2'd0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            parity_reg <= parity_next;
            pad_reg    <= pad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= emit;
        end
        else if (run.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            even_reg       <= map_nibble(body.data_byte[3:0], base_reg, transparent_reg);
            odd_reg        <= map_nibble(body.data_byte[7:4], base_reg, transparent_reg);
            rep_reg        <= rep;
            start_reg      <= col_reg;
            line_no_reg    <= row_reg;
            vis_reg        <= vis;
            line_done_reg  <= line_end;
            image_done_reg <= img_end;
        end
    end

    assign run.valid          = out_valid_reg;
    assign run.pixel_even     = even_reg;
    assign run.pixel_odd      = odd_reg;
    assign run.pair_repeat    = rep_reg;
    assign run.start_column   = start_reg;
    assign run.line_number    = line_no_reg;
    assign run.visible_pixels = vis_reg;
    assign run.line_done      = line_done_reg;
    assign run.image_done     = image_done_reg;

    // once the sprite has ended nothing leaves the done phase
    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("decoder left the done phase");

    // padding count lives only in the padding phase
    a_pad_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (pad_reg != 2'd0) == (phase_reg == PH_PAD))
        else $error("padding count out of step with phase");

    // a literal run never sits with no bytes left
    a_literal_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LITERAL) |-> (left_reg != 8'd0))
        else $error("literal phase with empty count");

    // a raw pair half-way through only happens in the idle phase
    a_parity_idle: assert property (@(posedge clk) disable iff (!rst_n)
        parity_reg |-> (phase_reg == PH_IDLE))
        else $error("raw pair open outside idle phase");

    // drawn pixels never exceed the run length
    a_vis_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, vis_reg} <= {1'b0, rep_reg, 1'b0}))
        else $error("visible pixels exceed run length");

endmodule
